// ===== hw/rtl/sqlkt_pkg.sv =====
`timescale 1ns / 1ps

package sqlkt_pkg;

    // Token kind codes.
    localparam logic [4:0] KIND_EOF        = 5'd0;
    localparam logic [4:0] KIND_MARK_FIRST = 5'd1;
    localparam logic [4:0] KIND_MARK_LAST  = 5'd8;
    localparam logic [4:0] KIND_STRING     = 5'd9;
    localparam logic [4:0] KIND_NUMBER     = 5'd10;
    localparam logic [4:0] KIND_IDENT      = 5'd11;
    localparam logic [4:0] KIND_UNKNOWN    = 5'd12;
    localparam logic [4:0] KIND_KEY_BASE   = 5'd13;

    // Most results one byte can cause, and the depth of the result queue.
    localparam int MAX_RESULTS = 3;
    localparam int Q_DEPTH     = 4;

    // Single-byte marks, in kind order starting at KIND_MARK_FIRST.
    localparam int MARK_COUNT = 8;
    localparam logic [7:0] MARK_CHARS [MARK_COUNT] = '{",", ";", "*", "=", ">", "<", "(", ")"};

    // Keywords, left-justified: character i sits in bits [8*(7-i) +: 8].
    // The first KW_EXACT_COUNT entries need an exact match, the rest a prefix match.
    localparam int KW_COUNT       = 14;
    localparam int KW_EXACT_COUNT = 12;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"SELECT", 16'h0}, {"FROM", 32'h0}, {"WHERE", 24'h0}, {"INSERT", 16'h0},
        {"INTO", 32'h0}, {"VALUES", 16'h0}, {"CREATE", 16'h0}, {"TABLE", 24'h0},
        "DATABASE", {"PRIMARY", 8'h0}, {"AND", 40'h0}, {"KEY", 40'h0},
        {"VARCHAR", 8'h0}, {"INT", 40'h0}
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd6, 8'd4, 8'd5, 8'd6, 8'd4, 8'd6, 8'd6, 8'd5, 8'd8, 8'd7, 8'd3, 8'd3, 8'd7, 8'd3
    };

    // First eight bytes of an identifier, upper case; index i is byte i.
    typedef logic [7:0][7:0] t_prefix;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [7:0]  token_length;
        logic        last_of_run;
    } t_out_beat;

    // Results of one byte, in order; vld marks the slots in use.
    typedef struct packed {
        logic [MAX_RESULTS-1:0]            vld;
        t_out_beat [MAX_RESULTS-1:0]       beat;
    } t_result_set;

endpackage

// ===== hw/rtl/sql_keyword_tokenizer_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                      | Beat
// ---------+-----------+--------------------------------+------------------------------
// in       | input     | i_in_valid / o_in_ready        | char_in, end_of_text
// out      | output    | o_out_valid / i_out_ready      | kind, start, length, last_of_run
//
// A byte is taken into an input register; when the queue has room, the lexer
// logic updates the scan state and writes zero to three result beats into a
// four-entry result queue. The lexer steps whenever the queue holds at most
// one beat, so one byte per cycle is sustained while results drain as fast as
// they are made; a byte that makes several results leaves them to drain from
// the queue, and the queue depth then sets how long the input stalls. Reset
// (synchronous, active low) returns the scanner to idle between tokens at
// offset zero and empties the queue.
module sql_keyword_tokenizer_core #(
    parameter int MAX_TOKEN = 255,
    parameter int POS_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sqlkt_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sqlkt_pkg::t_out_beat o_out_data
);
    import sqlkt_pkg::*;

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    // Input register: holds one byte until the lexer has room to step on it.
    logic        r_in_vld;
    t_in_beat    r_in;
    logic        step;
    t_result_set res;
    logic [CNT_W-1:0] q_count;

    // The lexer steps only when the queue can take the largest burst a byte
    // can produce, so no result is ever dropped.
    assign step       = r_in_vld && (q_count <= CNT_W'(Q_DEPTH - MAX_RESULTS));
    assign o_in_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    sqlkt_lexer #(
        .MAX_TOKEN (MAX_TOKEN),
        .POS_BITS  (POS_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_beat  (r_in),
        .o_res   (res)
    );

    sqlkt_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_en   (step),
        .i_push      (res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_count     (q_count)
    );

endmodule

// ===== hw/rtl/sqlkt_classify.sv =====
`timescale 1ns / 1ps

module sqlkt_classify (
    input  logic [7:0]       i_len,
    input  sqlkt_pkg::t_prefix i_prefix,
    output logic [4:0]       o_kind
);
    import sqlkt_pkg::*;

    logic [KW_COUNT-1:0] match;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            if (k < KW_EXACT_COUNT) begin
                match[k] = (i_len == KW_LEN[k]);
            end else begin
                match[k] = (i_len >= KW_LEN[k]);
            end
            for (int i = 0; i < 8; i++) begin
                if ((8'(i) < KW_LEN[k]) && (i_prefix[i] != KW_TEXT[k][8*(7-i) +: 8])) begin
                    match[k] = 1'b0;
                end
            end
        end
    end

    // The earliest keyword in the list wins, so INTO is found before INT.
    always_comb begin
        o_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (match[k]) begin
                o_kind = KIND_KEY_BASE + 5'(k);
            end
        end
    end

endmodule

// ===== hw/rtl/sqlkt_lexer.sv =====
`timescale 1ns / 1ps

module sqlkt_lexer #(
    parameter int MAX_TOKEN = 255,
    parameter int POS_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  sqlkt_pkg::t_in_beat    i_beat,
    output sqlkt_pkg::t_result_set o_res
);
    import sqlkt_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_IDENT  = 4'b1000
    } t_mode;

    t_mode               r_mode, n_mode, mode_a, mode_b;
    logic                r_quote_dbl, n_quote_dbl;
    logic [7:0]          r_len, n_len, len_a, len_b;
    logic [POS_BITS-1:0] r_start, n_start, start_b;
    logic [POS_BITS-1:0] r_pos, n_pos, pos_inc;
    t_prefix             r_prefix, n_prefix, prefix_a, prefix_b;

    logic [7:0] b, up_b;
    logic       is_dig, is_let, is_word, is_space, is_quote, at_max;
    logic       mark_hit;
    logic [4:0] mark_kind;
    logic       consumed;
    logic       f1_vld, f2_vld, f3_vld;
    logic [4:0] f1_kind, f2_kind, f3_kind;
    logic [4:0] pre_kind, post_kind;

    function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    sqlkt_classify u_pre_classify (
        .i_len    (r_len),
        .i_prefix (r_prefix),
        .o_kind   (pre_kind)
    );

    sqlkt_classify u_post_classify (
        .i_len    (len_b),
        .i_prefix (prefix_b),
        .o_kind   (post_kind)
    );

    assign b        = i_beat.char_in;
    assign is_dig   = (b >= "0") && (b <= "9");
    assign is_let   = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
    assign is_word  = is_let || is_dig || (b == "_");
    assign is_space = ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
    assign is_quote = (b == "'") || (b == "\"");
    assign up_b     = ((b >= "a") && (b <= "z")) ? (b - 8'h20) : b;
    assign at_max   = (r_len >= 8'(MAX_TOKEN));
    assign pos_inc  = (r_pos == '1) ? r_pos : (r_pos + 1'b1);

    always_comb begin
        mark_hit  = 1'b0;
        mark_kind = KIND_UNKNOWN;
        for (int k = 0; k < MARK_COUNT; k++) begin
            if (b == MARK_CHARS[k]) begin
                mark_hit  = 1'b1;
                mark_kind = KIND_MARK_FIRST + 5'(k);
            end
        end
    end

    // Continue or close the pending run.
    always_comb begin
        mode_a   = r_mode;
        len_a    = r_len;
        prefix_a = r_prefix;
        consumed = 1'b0;
        f1_vld   = 1'b0;
        f1_kind  = KIND_STRING;
        case (r_mode)
            MODE_STRING: begin
                if (b == (r_quote_dbl ? 8'("\"") : 8'("'"))) begin
                    f1_vld   = 1'b1;
                    mode_a   = MODE_IDLE;
                    consumed = 1'b1;
                end else if (at_max) begin
                    f1_vld = 1'b1;
                    mode_a = MODE_IDLE;
                end else begin
                    len_a    = r_len + 8'd1;
                    consumed = 1'b1;
                end
            end
            MODE_NUMBER: begin
                f1_kind = KIND_NUMBER;
                if (is_dig && !at_max) begin
                    len_a    = r_len + 8'd1;
                    consumed = 1'b1;
                end else begin
                    f1_vld = 1'b1;
                    mode_a = MODE_IDLE;
                end
            end
            MODE_IDENT: begin
                f1_kind = pre_kind;
                if (is_word && !at_max) begin
                    if (r_len < 8'd8) begin
                        prefix_a[r_len[2:0]] = up_b;
                    end
                    len_a    = r_len + 8'd1;
                    consumed = 1'b1;
                end else begin
                    f1_vld = 1'b1;
                    mode_a = MODE_IDLE;
                end
            end
            default: begin
                mode_a = MODE_IDLE;
            end
        endcase
    end

    // Start a new token from a byte the pending run did not take.
    always_comb begin
        mode_b      = mode_a;
        len_b       = len_a;
        start_b     = r_start;
        prefix_b    = prefix_a;
        n_quote_dbl = r_quote_dbl;
        f2_vld      = 1'b0;
        f2_kind     = mark_kind;
        if (!consumed && !is_space) begin
            if (mark_hit) begin
                f2_vld = 1'b1;
            end else if (is_quote) begin
                mode_b      = MODE_STRING;
                n_quote_dbl = (b == "\"");
                start_b     = pos_inc;
                len_b       = 8'd0;
            end else if (is_dig) begin
                mode_b  = MODE_NUMBER;
                start_b = r_pos;
                len_b   = 8'd1;
            end else if (is_let) begin
                mode_b      = MODE_IDENT;
                start_b     = r_pos;
                len_b       = 8'd1;
                prefix_b    = '0;
                prefix_b[0] = up_b;
            end else begin
                f2_vld = 1'b1;
            end
        end
    end

    // End of statement: flush whatever is open, then EOF.
    always_comb begin
        f3_vld  = i_beat.end_of_text;
        f3_kind = KIND_IDENT;
        case (mode_b)
            MODE_STRING: f3_kind = KIND_STRING;
            MODE_NUMBER: f3_kind = KIND_NUMBER;
            MODE_IDENT:  f3_kind = post_kind;
            default:     f3_vld  = 1'b0;
        endcase
    end

    always_comb begin
        n_prefix = prefix_b;
        if (i_beat.end_of_text) begin
            n_mode  = MODE_IDLE;
            n_len   = 8'd0;
            n_start = '0;
            n_pos   = '0;
        end else begin
            n_mode  = mode_b;
            n_len   = len_b;
            n_start = start_b;
            n_pos   = pos_inc;
        end
    end

    always_comb begin
        o_res.vld[0] = f1_vld;
        o_res.vld[1] = f2_vld || f3_vld;
        o_res.vld[2] = i_beat.end_of_text;

        o_res.beat[0].token_kind   = f1_kind;
        o_res.beat[0].token_start  = sat16(r_start);
        o_res.beat[0].token_length = r_len;
        o_res.beat[0].last_of_run  = f1_vld && !o_res.vld[1] && !o_res.vld[2];

        o_res.beat[1].token_kind   = f2_vld ? f2_kind : f3_kind;
        o_res.beat[1].token_start  = f2_vld ? sat16(r_pos) : sat16(start_b);
        o_res.beat[1].token_length = f2_vld ? 8'd1 : len_b;
        o_res.beat[1].last_of_run  = o_res.vld[1] && !o_res.vld[2];

        o_res.beat[2].token_kind   = KIND_EOF;
        o_res.beat[2].token_start  = sat16(pos_inc);
        o_res.beat[2].token_length = 8'd0;
        o_res.beat[2].last_of_run  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_quote_dbl <= 1'b0;
            r_len       <= 8'd0;
            r_start     <= '0;
            r_pos       <= '0;
            r_prefix    <= '0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_quote_dbl <= n_quote_dbl;
            r_len       <= n_len;
            r_start     <= n_start;
            r_pos       <= n_pos;
            r_prefix    <= n_prefix;
        end
    end

endmodule

// ===== hw/rtl/sqlkt_out_queue.sv =====
`timescale 1ns / 1ps

module sqlkt_out_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push_en,
    input  sqlkt_pkg::t_result_set i_push,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output sqlkt_pkg::t_out_beat   o_out_data,
    output logic [$clog2(sqlkt_pkg::Q_DEPTH+1)-1:0] o_count
);
    import sqlkt_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_out_beat        r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] w_idx [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] push_vld;
    logic [CNT_W-1:0] push_cnt;
    logic             pop;

    assign push_vld = i_push_en ? i_push.vld : '0;
    assign pop      = (r_count != '0) && i_out_ready;

    // Valid slots are packed in order behind the write pointer.
    always_comb begin
        push_cnt = '0;
        for (int j = 0; j < MAX_RESULTS; j++) begin
            w_idx[j] = r_wp + PTR_W'(push_cnt);
            push_cnt = push_cnt + CNT_W'(push_vld[j]);
        end
        n_wp    = r_wp + PTR_W'(push_cnt);
        n_rp    = r_rp + PTR_W'(pop);
        n_count = r_count + push_cnt - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (push_vld[j]) begin
                r_mem[w_idx[j]] <= i_push.beat[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rp];
    assign o_count     = r_count;

endmodule

// ===== hw/rtl/sqlkt_checker.sv =====
`timescale 1ns / 1ps

module sqlkt_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input sqlkt_pkg::t_in_beat  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input sqlkt_pkg::t_out_beat o_out_data
);
    import sqlkt_pkg::*;

    // A stalled input beat holds until the block takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while stalled");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // EOF is always empty and always closes the run of its byte.
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.token_kind == KIND_EOF)
        |-> o_out_data.last_of_run && (o_out_data.token_length == 8'd0))
        else $error("malformed EOF beat");

    // Marks and unknown bytes are single-byte tokens.
    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (((o_out_data.token_kind >= KIND_MARK_FIRST)
            && (o_out_data.token_kind <= KIND_MARK_LAST))
            || (o_out_data.token_kind == KIND_UNKNOWN))
        |-> (o_out_data.token_length == 8'd1))
        else $error("mark or unknown token with length other than one");

    // A keyword is never shorter than the shortest keyword.
    a_keyword_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.token_kind >= KIND_KEY_BASE)
        |-> (o_out_data.token_length >= 8'd3))
        else $error("keyword token too short");

endmodule

bind sql_keyword_tokenizer_core sqlkt_checker u_sqlkt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_lexer_pkg.sv =====
`timescale 1ns / 1ps

package tb_lexer_pkg;
    import sqlkt_pkg::*;

    localparam int unsigned MAX_RUN   = 255;
    localparam int unsigned POS_TOP   = 65535;
    localparam logic [7:0]  CH_SQUOTE = 8'h27;
    localparam logic [7:0]  CH_DQUOTE = 8'h22;
    localparam logic [7:0]  CH_UNDER  = 8'h5F;
    localparam int          REPORT_CAP = 40;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_STRING, SCAN_NUMBER, SCAN_IDENT} scan_t;

    // Tracks the lexer state alongside the block and holds the tokens still owed.
    class token_ledger;
        t_out_beat   pending[$];
        t_out_beat   made[$];
        int          errors;
        int          checked;
        int          kind_hits[32];
        int          most_per_byte;
        scan_t       mode;
        bit          dq;
        int unsigned run_len;
        int unsigned run_start;
        int unsigned pos;
        logic [7:0]  prefix[8];

        function new();
            mode = SCAN_IDLE;
            dq = 1'b0;
            run_len = 0;
            run_start = 0;
            pos = 0;
            foreach (prefix[i]) prefix[i] = 8'h00;
        endfunction

        function int unsigned bump(int unsigned p);
            return (p >= POS_TOP) ? p : p + 1;
        endfunction

        function logic [7:0] upcase(logic [7:0] b);
            return (b >= "a" && b <= "z") ? b - 8'd32 : b;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_letter(logic [7:0] b);
            return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
        endfunction

        function void add_token(logic [4:0] kind, int unsigned start, int unsigned len);
            t_out_beat t;
            t.token_kind   = kind;
            t.token_start  = (start > POS_TOP) ? 16'hFFFF : 16'(start);
            t.token_length = 8'(len);
            t.last_of_run  = 1'b0;
            made.push_back(t);
        endfunction

        function bit prefix_matches(int k);
            for (int i = 0; i < KW_LEN[k] && i < 8; i++)
                if (prefix[i] != KW_TEXT[k][8*(7-i) +: 8]) return 1'b0;
            return 1'b1;
        endfunction

        // Exact keywords are tried first, then the two prefix keywords.
        function logic [4:0] word_kind();
            for (int k = 0; k < KW_COUNT; k++) begin
                if ((k < KW_EXACT_COUNT) ? (run_len == KW_LEN[k]) : (run_len >= KW_LEN[k]))
                    if (prefix_matches(k)) return 5'(KIND_KEY_BASE + k);
            end
            return KIND_IDENT;
        endfunction

        function void close_run();
            case (mode)
                SCAN_STRING: add_token(KIND_STRING, run_start, run_len);
                SCAN_NUMBER: add_token(KIND_NUMBER, run_start, run_len);
                SCAN_IDENT:  add_token(word_kind(), run_start, run_len);
                default: ;
            endcase
            mode = SCAN_IDLE;
        endfunction

        function void note_byte(t_in_beat beat);
            logic [7:0]  b;
            int unsigned here;
            bit          taken;
            int          mark;
            b = beat.char_in;
            here = pos;
            taken = 1'b0;
            made.delete();

            case (mode)
                SCAN_STRING: begin
                    if (b == (dq ? CH_DQUOTE : CH_SQUOTE)) begin
                        close_run();
                        taken = 1'b1;
                    end else if (run_len >= MAX_RUN) begin
                        close_run();
                    end else begin
                        run_len++;
                        taken = 1'b1;
                    end
                end
                SCAN_NUMBER: begin
                    if (is_digit(b) && run_len < MAX_RUN) begin
                        run_len++;
                        taken = 1'b1;
                    end else begin
                        close_run();
                    end
                end
                SCAN_IDENT: begin
                    if ((is_letter(b) || is_digit(b) || b == CH_UNDER) && run_len < MAX_RUN) begin
                        if (run_len < 8) prefix[run_len] = upcase(b);
                        run_len++;
                        taken = 1'b1;
                    end else begin
                        close_run();
                    end
                end
                default: ;
            endcase

            // A byte that did not extend a run starts something new.
            if (!taken && !((b >= 8'd9 && b <= 8'd13) || b == 8'd32)) begin
                mark = -1;
                for (int k = 0; k < MARK_COUNT; k++)
                    if (b == MARK_CHARS[k]) mark = k;
                if (mark >= 0) begin
                    add_token(5'(KIND_MARK_FIRST + mark), here, 1);
                end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
                    mode = SCAN_STRING;
                    dq = (b == CH_DQUOTE);
                    run_start = bump(here);
                    run_len = 0;
                end else if (is_digit(b)) begin
                    mode = SCAN_NUMBER;
                    run_start = here;
                    run_len = 1;
                end else if (is_letter(b)) begin
                    mode = SCAN_IDENT;
                    run_start = here;
                    run_len = 1;
                    foreach (prefix[i]) prefix[i] = 8'h00;
                    prefix[0] = upcase(b);
                end else begin
                    add_token(KIND_UNKNOWN, here, 1);
                end
            end

            pos = bump(here);
            if (beat.end_of_text) begin
                close_run();
                add_token(KIND_EOF, pos, 0);
                pos = 0;
                run_len = 0;
                run_start = 0;
            end

            if (made.size() > 0) made[made.size()-1].last_of_run = 1'b1;
            if (made.size() > most_per_byte) most_per_byte = made.size();
            foreach (made[i]) begin
                kind_hits[made[i].token_kind]++;
                pending.push_back(made[i]);
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_token(t_out_beat got);
            t_out_beat want;
            if (pending.size() == 0) begin
                report($sformatf("token kind %0d start %0d length %0d with none due",
                                 got.token_kind, got.token_start, got.token_length));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.token_kind !== want.token_kind)
                report($sformatf("token %0d kind %0d, want %0d",
                                 checked, got.token_kind, want.token_kind));
            if (got.token_start !== want.token_start)
                report($sformatf("token %0d start %0d, want %0d",
                                 checked, got.token_start, want.token_start));
            if (got.token_length !== want.token_length)
                report($sformatf("token %0d length %0d, want %0d",
                                 checked, got.token_length, want.token_length));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("token %0d last flag %0b, want %0b",
                                 checked, got.last_of_run, want.last_of_run));
        endtask
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sqlkt_pkg::*;
    import tb_lexer_pkg::*;

    localparam int          CLK_PERIOD   = 8;
    localparam int          RESET_CYCLES = 5;
    localparam int          RANDOM_BYTES = 50;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 20;
    // The run is stopped and reported as failed if the cycle count reaches this limit.
    localparam int unsigned CYCLE_LIMIT  = 200_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    token_ledger ledger = new();

    // Bytes of the statement being built; the last one carries the end flag.
    logic [7:0]  text_q[$];
    int          statements = 0;
    int          random_bytes = 0;
    int unsigned cycle_count = 0;
    int          rx_pause = 0;
    bit          steady = 1'b0;
    bit          pressure_go = 1'b0;
    logic        rx_hold = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    sql_keyword_tokenizer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Gap lengths: mostly none or short, now and then a long one. While steady
    // is set, neither side adds a random gap.
    function automatic int pause_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // One token of a well-formed statement, with random spelling and content.
    function automatic void add_random_token();
        int         k;
        int         n;
        logic [7:0] c;
        logic [7:0] q;
        case ($urandom_range(0, 9))
            0: begin
                // A keyword in mixed case, sometimes lengthened or clipped so that
                // the exact and prefix rules both get exercised.
                k = $urandom_range(0, KW_COUNT - 1);
                for (int i = 0; i < KW_LEN[k]; i++) begin
                    c = KW_TEXT[k][8*(7-i) +: 8];
                    if ($urandom_range(0, 1)) c = c | 8'h20;
                    text_q.push_back(c);
                end
                n = $urandom_range(0, 5);
                if (n == 0) text_q.push_back(word_char());
                else if (n == 1) void'(text_q.pop_back());
            end
            1, 2: begin
                text_q.push_back(8'("A" + $urandom_range(0, 25))
                                 | 8'($urandom_range(0, 1) << 5));
                repeat ($urandom_range(0, 11)) text_q.push_back(word_char());
            end
            3: repeat ($urandom_range(1, 10)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
            4: begin
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                text_q.push_back(q);
                repeat ($urandom_range(0, 10)) begin
                    c = 8'($urandom_range(1, 255));
                    text_q.push_back((c == q) ? 8'h61 : c);
                end
                // Now and then the string is left open and swallows the rest.
                if ($urandom_range(0, 7) != 0) text_q.push_back(q);
            end
            5, 6: text_q.push_back(MARK_CHARS[$urandom_range(0, MARK_COUNT - 1)]);
            7: text_q.push_back(8'($urandom_range(1, 255)));
            8: text_q.push_back(space_char());
            default: repeat ($urandom_range(9, 14)) text_q.push_back(word_char());
        endcase
        if ($urandom_range(0, 9) < 7) text_q.push_back(space_char());
    endfunction

    // Offer one beat and hold it until the block takes it. Valid stays high into
    // the next beat unless a gap follows.
    task automatic send_beat(t_in_beat beat);
        int g;
        i_in_data  <= beat;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.note_byte(beat);
        g = pause_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_text();
        t_in_beat beat;
        foreach (text_q[i]) begin
            beat.char_in     = text_q[i];
            beat.end_of_text = (i == text_q.size() - 1);
            send_beat(beat);
        end
        text_q.delete();
        statements++;
    endtask

    // Sink side: check every accepted token, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) ledger.check_token(o_out_data);
        if (rx_pause > 0) rx_pause = rx_pause - 1;
        else rx_pause = pause_len();
        i_out_ready <= (rx_pause == 0) && !rx_hold;
    end

    // Switch between stretches with random idling and stretches with none.
    always begin
        repeat ($urandom_range(100, 300)) @(posedge i_clk);
        steady <= ($urandom_range(0, 3) == 0);
    end

    // Once the random traffic starts, the sink refuses tokens for a long while so
    // the result queue fills and the block has to stall its input.
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int kinds_seen;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed statements. Keywords in mixed case, marks, words and a number.
        put_str("Select * from T where a=1;");
        send_text();
        // Prefix keywords and near misses: VARCHAR and INT as prefixes, INTO exact.
        put_str("VARCHAR9 INTOx into int");
        send_text();
        // A number cut short by a mark on the final byte: three tokens from one beat.
        put_str("12,");
        send_text();
        // A string still open at the final byte, a closed one followed by an empty
        // one, and one opened on the final byte.
        put_str("'ab");
        send_text();
        put_str("\"it's\"''");
        send_text();
        put_str("'");
        send_text();
        // Marks, unknown bytes including a high one, and trailing whitespace so the
        // statement ends on a byte that makes nothing but EOF.
        put_str("#()<>");
        text_q.push_back(8'h80);
        text_q.push_back(8'h09);
        send_text();

        // Random statements: mostly well formed, some pure noise.
        pressure_go = 1'b1;
        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(1, 255)));
            else
                repeat ($urandom_range(1, 3)) add_random_token();
            if (text_q.size() == 0) text_q.push_back(space_char());
            random_bytes += text_q.size();
            send_text();
        end
        i_in_valid <= 1'b0;

        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        kinds_seen = 0;
        foreach (ledger.kind_hits[i]) if (ledger.kind_hits[i] > 0) kinds_seen++;
        $display("Run covered %0d statements, %0d tokens checked, %0d of 27 token kinds.",
                 statements, ledger.checked, kinds_seen);
        $display("Up to %0d tokens came from one byte; the sink once held off %0d cycles.",
                 ledger.most_per_byte, HOLD_CYCLES);
        if (ledger.errors == 0 && ledger.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
